### rtl/core/thsup_pkg.sv
// Shared types and constants of the thermal alarm supervisor.
`default_nettype none

package thsup_pkg;

   // Field widths
   localparam int ADC_W  = 12;  // raw sensor sample
   localparam int DEG_W  = 9;   // whole degrees, 0..500
   localparam int WIN_W  = 8;   // acknowledge window / failing hold
   localparam int COOL_W = 10;  // cooling countdown
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   // Remainder width for averaging; covers the widest sample count (16)
   localparam int REM_W  = 4;

   // Conversion: degrees = floor(raw * DEG_SCALE / ADC_FULL)
   localparam int DEG_SCALE = 500;
   localparam int ADC_FULL  = 4095;
   localparam int PROD_W    = 21;

   // Reset values of the configuration registers
   localparam logic [DEG_W-1:0]  OK_LIMIT_RESET      = 9'd35;
   localparam logic [DEG_W-1:0]  DANGER_LIMIT_RESET  = 9'd46;
   localparam logic [WIN_W-1:0]  ACK_WINDOW_RESET    = 8'd25;
   localparam logic [COOL_W-1:0] COOLING_TICKS_RESET = 10'd100;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OK_LIMIT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DANGER_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_WINDOW   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLING      = 2'd3;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_START   = 2'd1,
      CMD_ACK     = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_OFF      = 3'd0,
      MODE_CHECK    = 3'd1,
      MODE_OK       = 3'd2,
      MODE_DANGER   = 3'd3,
      MODE_WARNING  = 3'd4,
      MODE_COOLING  = 3'd5,
      MODE_FAILING  = 3'd6,
      MODE_SHUTDOWN = 3'd7
   } mode_type;

   typedef struct packed {
      logic [DEG_W-1:0]  ok_limit;
      logic [DEG_W-1:0]  danger_limit;
      logic [WIN_W-1:0]  ack_window_ticks;
      logic [COOL_W-1:0] cooling_ticks;
   } cfg_type;

   // Decoded event word between front and back: the sample's degrees
   // already split into quotient and remainder by the sample count.
   typedef struct packed {
      cmd_type          cmd;
      logic [DEG_W-1:0] deg_quot;
      logic [REM_W-1:0] deg_rem;
   } event_word_type;

   typedef struct packed {
      mode_type         mode;
      logic             red_led;
      logic             yellow_led;
      logic             green_led;
      logic [DEG_W-1:0] average_degrees;
      logic             passthrough_on;
   } rsp_word_type;

endpackage

`default_nettype wire

### rtl/core/thsup_fifo.sv
// Small register FIFO with push/full and pop/empty sides.
`default_nettype none

module thsup_fifo #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    head_ff, head_in;
   logic [AW-1:0]    tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + AW'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/core/thsup_front.sv
// Front end: accepts events, converts samples to degrees and splits them.
`default_nettype none

module thsup_front #(
   parameter int SAMPLES_PER_AVERAGE = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   output logic                              full,
   input  wire logic [1:0]                   command,
   input  wire logic [thsup_pkg::ADC_W-1:0]  adc_sample,
   output logic                              word_valid,
   output thsup_pkg::event_word_type         word,
   input  wire logic                         queue_full
);
   import thsup_pkg::*;

   // Exact reciprocal for 9-bit dividends
   localparam int RECIP_SHIFT = DEG_W + $clog2(SAMPLES_PER_AVERAGE);
   localparam int RECIP_W     = DEG_W + 2;
   localparam int RECIP       =
      ((1 << RECIP_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
   localparam int RP_W        = DEG_W + RECIP_W;
   localparam int DIFF_W      = DEG_W + 5;

   logic                  advance;
   // stage 1: product
   logic                  v1_ff;
   cmd_type               cmd1_ff;
   logic [PROD_W-1:0]     prod1_ff;
   // stage 2: degrees
   logic                  v2_ff;
   cmd_type               cmd2_ff;
   logic [DEG_W-1:0]      deg2_ff;
   // stage 3: quotient
   logic                  v3_ff;
   cmd_type               cmd3_ff;
   logic [DEG_W-1:0]      deg3_ff;
   logic [DEG_W-1:0]      quot3_ff;

   logic [PROD_W:0]       approx_sum;
   logic [DEG_W:0]        quot_est;
   logic [PROD_W:0]       quot_rem;
   logic [DEG_W-1:0]      deg_val;
   logic [RP_W-1:0]       recip_prod;
   logic [DIFF_W-1:0]     rem_diff;

   assign advance    = !(v3_ff && queue_full);
   assign full       = !advance;
   assign word_valid = v3_ff;

   // x/4095 estimate from x/4096 * (1 + 1/4096), low by at most one
   always_comb begin
      approx_sum = {1'b0, prod1_ff} + ({1'b0, prod1_ff} >> 12);
      quot_est   = approx_sum[PROD_W:12];
      quot_rem   = {1'b0, prod1_ff} - ((PROD_W+1)'(quot_est) << 12)
                   + (PROD_W+1)'(quot_est);
      deg_val    = (quot_rem >= (PROD_W+1)'(ADC_FULL))
                   ? DEG_W'(quot_est + (DEG_W+1)'(1)) : DEG_W'(quot_est);
   end

   assign recip_prod = RP_W'(deg2_ff) * RP_W'(RECIP);
   assign rem_diff   = DIFF_W'(deg3_ff)
                       - DIFF_W'(quot3_ff) * DIFF_W'(SAMPLES_PER_AVERAGE);

   assign word.cmd      = cmd3_ff;
   assign word.deg_quot = quot3_ff;
   assign word.deg_rem  = rem_diff[REM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= push;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd1_ff  <= cmd_type'(command);
         prod1_ff <= PROD_W'(adc_sample) * PROD_W'(DEG_SCALE);
         cmd2_ff  <= cmd1_ff;
         deg2_ff  <= deg_val;
         cmd3_ff  <= cmd2_ff;
         deg3_ff  <= deg2_ff;
         quot3_ff <= DEG_W'(recip_prod >> RECIP_SHIFT);
      end
   end

endmodule

`default_nettype wire

### rtl/core/thsup_back.sv
// Back end state machine: one event word per cycle unless stalled.
`default_nettype none

module thsup_back #(
   parameter int SAMPLES_PER_AVERAGE = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire thsup_pkg::cfg_type         cfg,
   input  wire thsup_pkg::event_word_type  in_word,
   input  wire logic                       in_empty,
   output logic                            in_pop,
   input  wire logic                       out_full,
   output logic                            out_push,
   output thsup_pkg::rsp_word_type         out_word
);
   import thsup_pkg::*;

   localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);

   mode_type          mode_ff, mode_in;
   logic [2:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DEG_W-1:0]  quot_ff, quot_in;    // running sum / samples
   logic [REM_W-1:0]  rem_ff, rem_in;      // running sum % samples
   logic [DEG_W-1:0]  avg_ff, avg_in;
   logic [WIN_W-1:0]  window_ff, window_in;
   logic [COOL_W-1:0] cool_ff, cool_in;
   logic              ack_ff, ack_in;
   logic              red_ff, red_in;
   logic              yellow_ff, yellow_in;
   logic              green_ff, green_in;

   logic [WIN_W-1:0]  win_next;
   logic [REM_W:0]    rem_sum;
   logic              rem_carry;
   logic [3:0]        blink_res;

   // returns {led level, next phase}
   function automatic logic [3:0] blink_step(input logic [2:0] phase);
      logic [3:0] res;
      if (phase < 3'd2) begin
         res = {1'b1, phase + 3'd1};
      end else if (phase < 3'd4) begin
         res = {1'b0, phase + 3'd1};
      end else begin
         res = 4'b0000;
      end
      return res;
   endfunction

   assign in_pop   = !in_empty && !out_full;
   assign out_push = in_pop;

   assign win_next  = window_ff + WIN_W'(1);
   assign rem_sum   = {1'b0, rem_ff} + {1'b0, in_word.deg_rem};
   assign rem_carry = (rem_sum >= (REM_W+1)'(SAMPLES_PER_AVERAGE));

   // next state
   always_comb begin
      mode_in   = mode_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      avg_in    = avg_ff;
      window_in = window_ff;
      cool_in   = cool_ff;
      ack_in    = ack_ff;
      red_in    = red_ff;
      yellow_in = yellow_ff;
      green_in  = green_ff;
      blink_res = blink_step(phase_ff);
      if (in_pop) begin
         case (in_word.cmd)
            CMD_TICK: begin
               if (mode_ff != MODE_OFF && mode_ff != MODE_SHUTDOWN) begin
                  case (mode_ff)
                     MODE_CHECK: begin
                        phase_in  = blink_res[2:0];
                        yellow_in = blink_res[3];
                     end
                     MODE_DANGER: begin
                        phase_in  = blink_res[2:0];
                        red_in    = blink_res[3];
                        window_in = win_next;
                        if (win_next >= cfg.ack_window_ticks) begin
                           window_in = '0;
                           if (!ack_ff) begin
                              red_in    = 1'b0;
                              yellow_in = 1'b0;
                              green_in  = 1'b0;
                              mode_in   = MODE_SHUTDOWN;
                           end else begin
                              ack_in = 1'b0;
                           end
                        end
                     end
                     MODE_COOLING: begin
                        if (cool_ff != '0) begin
                           cool_in = cool_ff - COOL_W'(1);
                        end else begin
                           cool_in = cfg.cooling_ticks;
                           red_in  = 1'b0;
                           if (avg_ff > cfg.ok_limit) begin
                              window_in = '0;
                              mode_in   = MODE_FAILING;
                           end else begin
                              yellow_in = 1'b0;
                              green_in  = 1'b1;
                              mode_in   = MODE_OK;
                           end
                        end
                     end
                     MODE_FAILING: begin
                        if (window_ff < cfg.ack_window_ticks) begin
                           window_in = win_next;
                        end else begin
                           red_in    = 1'b0;
                           yellow_in = 1'b0;
                           green_in  = 1'b0;
                           window_in = '0;
                           mode_in   = MODE_SHUTDOWN;
                        end
                     end
                     default: ;
                  endcase

                  if (count_ff < CNT_W'(SAMPLES_PER_AVERAGE)) begin
                     count_in = count_ff + CNT_W'(1);
                     rem_in   = rem_carry
                                ? REM_W'(rem_sum - (REM_W+1)'(SAMPLES_PER_AVERAGE))
                                : rem_sum[REM_W-1:0];
                     quot_in  = quot_ff + in_word.deg_quot + DEG_W'(rem_carry);
                  end else begin
                     avg_in   = quot_ff;
                     quot_in  = '0;
                     rem_in   = '0;
                     count_in = '0;
                     if (mode_in != MODE_COOLING && mode_in != MODE_FAILING &&
                         mode_in != MODE_SHUTDOWN) begin
                        phase_in = '0;
                        if (quot_ff <= cfg.ok_limit) begin
                           red_in    = 1'b0;
                           yellow_in = 1'b0;
                           green_in  = 1'b1;
                           mode_in   = MODE_OK;
                        end else if (quot_ff >= cfg.danger_limit) begin
                           yellow_in = 1'b0;
                           green_in  = 1'b0;
                           mode_in   = MODE_DANGER;
                        end else begin
                           red_in    = 1'b0;
                           green_in  = 1'b0;
                           yellow_in = 1'b1;
                           mode_in   = MODE_WARNING;
                        end
                     end
                  end
               end
            end
            CMD_START, CMD_RESTART: begin
               if ((in_word.cmd == CMD_START && mode_ff == MODE_OFF) ||
                   (in_word.cmd == CMD_RESTART && mode_ff == MODE_SHUTDOWN)) begin
                  mode_in  = MODE_CHECK;
                  count_in = '0;
                  quot_in  = '0;
                  rem_in   = '0;
                  avg_in   = '0;
                  phase_in = '0;
               end
            end
            CMD_ACK: begin
               if (mode_ff == MODE_DANGER) begin
                  mode_in = MODE_COOLING;
                  ack_in  = 1'b1;
                  red_in  = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // result word: state after the event
   always_comb begin
      out_word.mode            = mode_in;
      out_word.red_led         = red_in;
      out_word.yellow_led      = yellow_in;
      out_word.green_led       = green_in;
      out_word.average_degrees = avg_in;
      out_word.passthrough_on  = (mode_in == MODE_OK) || (mode_in == MODE_WARNING);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_OFF;
         phase_ff  <= '0;
         count_ff  <= '0;
         quot_ff   <= '0;
         rem_ff    <= '0;
         avg_ff    <= '0;
         window_ff <= '0;
         cool_ff   <= COOLING_TICKS_RESET;
         ack_ff    <= 1'b0;
         red_ff    <= 1'b0;
         yellow_ff <= 1'b0;
         green_ff  <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         quot_ff   <= quot_in;
         rem_ff    <= rem_in;
         avg_ff    <= avg_in;
         window_ff <= window_in;
         cool_ff   <= cool_in;
         ack_ff    <= ack_in;
         red_ff    <= red_in;
         yellow_ff <= yellow_in;
         green_ff  <= green_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/thermal_alarm_supervisor.sv
// Top level of the thermal alarm supervisor: config registers and queues.
//
// Usage:
//  - Input channel (req_): one event word per accepted push (push high, full
//    low): a tick carrying a 12-bit sample, or a start, acknowledge or
//    restart press.
//  - Result channel (rsp_): exactly one result word per event, in order,
//    shown while empty is low and taken on pop high.
//  - Config (csr_): csr_wr_en writes csr_wdata to register csr_index at the
//    clock edge; write only while the block is idle.
//  - Path: an accepted event passes the three front stages, the event
//    queue and the back state step before its result is on the rsp_ ports.
//  - Throughput: one word per cycle while no stall (below) holds the flow;
//    the back end updates all supervisor state at once for each event.
//  - Stall: if pop stays low, the result queue fills, the back end stops
//    draining the event queue, and full rises once the front pipe backs up.
//    Nothing is dropped.
//  - Reset: synchronous; both queues empty, mode off, LEDs off, registers
//    at their reset values. No clearing pass is needed.
`default_nettype none

module thermal_alarm_supervisor #(
   parameter int SAMPLES_PER_AVERAGE = 10,
   parameter int QUEUE_DEPTH         = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // event words
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_command,
   input  wire logic [11:0] req_adc_sample,
   // result words
   output logic             empty,
   input  wire logic        pop,
   output logic [2:0]       rsp_mode,
   output logic             rsp_red_led,
   output logic             rsp_yellow_led,
   output logic             rsp_green_led,
   output logic [8:0]       rsp_average_degrees,
   output logic             rsp_passthrough_on,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_wdata
);
   import thsup_pkg::*;

   localparam int EV_W  = $bits(event_word_type);
   localparam int RSP_W = $bits(rsp_word_type);

   cfg_type        cfg_ff, cfg_in;
   event_word_type front_word;
   logic           front_valid;
   logic           ev_full, ev_empty, ev_pop;
   logic [EV_W-1:0] ev_data;
   event_word_type ev_word;
   rsp_word_type   back_word;
   logic           back_push;
   logic           rsp_full;
   logic [RSP_W-1:0] rsp_data;
   rsp_word_type   rsp_word;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_OK_LIMIT:     cfg_in.ok_limit         = csr_wdata[DEG_W-1:0];
            CSR_DANGER_LIMIT: cfg_in.danger_limit     = csr_wdata[DEG_W-1:0];
            CSR_ACK_WINDOW:   cfg_in.ack_window_ticks = csr_wdata[WIN_W-1:0];
            CSR_COOLING:      cfg_in.cooling_ticks    = csr_wdata[COOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ok_limit         <= OK_LIMIT_RESET;
         cfg_ff.danger_limit     <= DANGER_LIMIT_RESET;
         cfg_ff.ack_window_ticks <= ACK_WINDOW_RESET;
         cfg_ff.cooling_ticks    <= COOLING_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept, convert to degrees, split by sample count
   thsup_front #(
      .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .command    (req_command),
      .adc_sample (req_adc_sample),
      .word_valid (front_valid),
      .word       (front_word),
      .queue_full (ev_full)
   );

   // Event queue between front and back
   thsup_fifo #(
      .WIDTH (EV_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ev_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_word),
      .full      (ev_full),
      .pop       (ev_pop),
      .pop_data  (ev_data),
      .empty     (ev_empty)
   );

   assign ev_word = event_word_type'(ev_data);

   // Back: supervisor state step
   thsup_back #(
      .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_word  (ev_word),
      .in_empty (ev_empty),
      .in_pop   (ev_pop),
      .out_full (rsp_full),
      .out_push (back_push),
      .out_word (back_word)
   );

   // Result queue; its head drives the rsp_ ports
   thsup_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_word),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

   assign rsp_word            = rsp_word_type'(rsp_data);
   assign rsp_mode            = rsp_word.mode;
   assign rsp_red_led         = rsp_word.red_led;
   assign rsp_yellow_led      = rsp_word.yellow_led;
   assign rsp_green_led       = rsp_word.green_led;
   assign rsp_average_degrees = rsp_word.average_degrees;
   assign rsp_passthrough_on  = rsp_word.passthrough_on;

   // Back end never steps while the result queue has no room
   a_back_room: assert property (@(posedge clock) disable iff (reset)
      ev_pop |-> !rsp_full)
      else $error("back end stepped with result queue full");

   // Every back step produces exactly one result word
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      ev_pop == back_push)
      else $error("event step and result push out of lockstep");

   // Stopped modes show no LED
   a_stopped_dark: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_mode == MODE_OFF || rsp_mode == MODE_SHUTDOWN)) |->
      (!rsp_red_led && !rsp_yellow_led && !rsp_green_led))
      else $error("LED lit in off or shutdown mode");

   // Passthrough follows the shown mode
   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_passthrough_on ==
                  (rsp_mode == MODE_OK || rsp_mode == MODE_WARNING)))
      else $error("passthrough does not match mode");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result pending after reset");

endmodule

`default_nettype wire

### test/tb_thermal_alarm_supervisor.sv
// Testbench of the thermal alarm supervisor: scoreboard class, stimulus and checks.
`timescale 1ns / 100ps

module tb_thermal_alarm_supervisor;
   import thsup_pkg::*;

   localparam int SAMPLES = 10;   // ticks summed per average

   // LED positions in the predicted level vector
   localparam int LED_RED    = 0;
   localparam int LED_YELLOW = 1;
   localparam int LED_GREEN  = 2;

   // Bench-side wiring; every block input has a known value from time zero
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  push           = 1'b0;
   logic                  full;
   logic [1:0]            req_command    = CMD_TICK;
   logic [ADC_W-1:0]      req_adc_sample = '0;
   logic                  empty;
   logic                  pop            = 1'b0;
   logic [2:0]            rsp_mode;
   logic                  rsp_red_led;
   logic                  rsp_yellow_led;
   logic                  rsp_green_led;
   logic [DEG_W-1:0]      rsp_average_degrees;
   logic                  rsp_passthrough_on;
   logic                  csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = CSR_OK_LIMIT;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   //--------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the supervisor state, predicts one
   // status word per accepted event word and checks returned words in order.
   //--------------------------------------------------------------------------
   class alarm_scoreboard;
      logic [DEG_W-1:0]  ok_limit;
      logic [DEG_W-1:0]  danger_limit;
      logic [WIN_W-1:0]  ack_window;
      logic [COOL_W-1:0] cooling_reload;
      mode_type          mode;
      int unsigned       blink_phase;
      int unsigned       sample_count;
      logic [12:0]       sample_sum;
      logic [DEG_W-1:0]  average;
      logic [WIN_W-1:0]  window_count;
      logic [COOL_W-1:0] cooling_count;
      bit                ack_flag;
      logic [2:0]        leds;
      rsp_word_type      pending_status[$];
      int unsigned       accepted;
      int unsigned       acted;
      int unsigned       checked;
      int unsigned       mismatches;
      int unsigned       unexpected;
      int unsigned       mode_entries[8];

      function new();
         ok_limit       = OK_LIMIT_RESET;
         danger_limit   = DANGER_LIMIT_RESET;
         ack_window     = ACK_WINDOW_RESET;
         cooling_reload = COOLING_TICKS_RESET;
         mode           = MODE_OFF;
         blink_phase    = 0;
         sample_count   = 0;
         sample_sum     = '0;
         average        = '0;
         window_count   = '0;
         cooling_count  = COOLING_TICKS_RESET;   // 100 until the first reload
         ack_flag       = 1'b0;
         leds           = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_OK_LIMIT:     ok_limit       = data[DEG_W-1:0];
            CSR_DANGER_LIMIT: danger_limit   = data[DEG_W-1:0];
            CSR_ACK_WINDOW:   ack_window     = data[WIN_W-1:0];
            CSR_COOLING:      cooling_reload = data[COOL_W-1:0];
         endcase
      endfunction

      // two phases on, two off, then one more off before wrapping
      function void blink(int led);
         if (blink_phase < 2) begin
            blink_phase++;
            leds[led] = 1'b1;
         end else if (blink_phase < 4) begin
            blink_phase++;
            leds[led] = 1'b0;
         end else begin
            blink_phase = 0;
            leds[led]   = 1'b0;
         end
      endfunction

      function void enter_shutdown();
         leds         = '0;
         window_count = '0;
         mode         = MODE_SHUTDOWN;
      endfunction

      function void enter_check();
         mode         = MODE_CHECK;
         sample_count = 0;
         sample_sum   = '0;
         average      = '0;
         blink_phase  = 0;
      endfunction

      function void sort_by_average();
         blink_phase = 0;
         if (average <= ok_limit) begin
            leds[LED_RED]    = 1'b0;
            leds[LED_YELLOW] = 1'b0;
            leds[LED_GREEN]  = 1'b1;
            mode = MODE_OK;
         end else if (average >= danger_limit) begin
            leds[LED_YELLOW] = 1'b0;
            leds[LED_GREEN]  = 1'b0;
            mode = MODE_DANGER;
         end else begin
            leds[LED_RED]    = 1'b0;
            leds[LED_GREEN]  = 1'b0;
            leds[LED_YELLOW] = 1'b1;
            mode = MODE_WARNING;
         end
      endfunction

      function void advance_tick(logic [ADC_W-1:0] raw);
         int unsigned degrees;
         degrees = (int'(raw) * DEG_SCALE) / ADC_FULL;
         case (mode)
            MODE_CHECK: blink(LED_YELLOW);
            MODE_DANGER: begin
               blink(LED_RED);
               window_count = window_count + 1'b1;
               if (window_count >= ack_window) begin
                  if (!ack_flag) begin
                     enter_shutdown();
                  end else begin
                     window_count = '0;
                     ack_flag     = 1'b0;
                  end
               end
            end
            MODE_COOLING: begin
               if (cooling_count > 0) begin
                  cooling_count--;
               end else begin
                  cooling_count = cooling_reload;
                  leds[LED_RED] = 1'b0;
                  if (average > ok_limit) begin
                     window_count = '0;
                     mode = MODE_FAILING;
                  end else begin
                     leds[LED_YELLOW] = 1'b0;
                     leds[LED_GREEN]  = 1'b1;
                     mode = MODE_OK;
                  end
               end
            end
            MODE_FAILING: begin
               if (window_count < ack_window) window_count++;
               else enter_shutdown();
            end
            default: ;
         endcase
         // sampling goes on even in the tick that shut the block down
         if (sample_count < SAMPLES) begin
            sample_sum = sample_sum + 13'(degrees);
            sample_count++;
         end else begin
            average      = DEG_W'(sample_sum / SAMPLES);
            sample_sum   = '0;
            sample_count = 0;
            if (mode != MODE_COOLING && mode != MODE_FAILING && mode != MODE_SHUTDOWN)
               sort_by_average();
         end
      endfunction

      // returns one when the event word changed anything
      function bit note_input(cmd_type cmd, logic [ADC_W-1:0] raw);
         mode_type     prior;
         rsp_word_type status;
         bit           took;
         prior = mode;
         took  = 1'b0;
         case (cmd)
            CMD_TICK: if (mode != MODE_OFF && mode != MODE_SHUTDOWN) begin
               took = 1'b1;
               advance_tick(raw);
            end
            CMD_START: if (mode == MODE_OFF) begin
               took = 1'b1;
               enter_check();
            end
            CMD_ACK: if (mode == MODE_DANGER) begin
               took = 1'b1;
               mode = MODE_COOLING;
               ack_flag = 1'b1;
               leds[LED_RED] = 1'b1;
            end
            CMD_RESTART: if (mode == MODE_SHUTDOWN) begin
               took = 1'b1;
               enter_check();
            end
         endcase
         if (mode != prior) mode_entries[mode]++;
         status.mode            = mode;
         status.red_led         = leds[LED_RED];
         status.yellow_led      = leds[LED_YELLOW];
         status.green_led       = leds[LED_GREEN];
         status.average_degrees = average;
         status.passthrough_on  = (mode == MODE_OK || mode == MODE_WARNING);
         pending_status.push_back(status);
         accepted++;
         if (took) acted++;
         return took;
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (pending_status.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("ERROR: status word with nothing pending: mode %0d avg %0d",
                        got.mode, got.average_degrees);
            return;
         end
         want = pending_status.pop_front();
         checked++;
         if (got.mode !== want.mode || got.red_led !== want.red_led ||
             got.yellow_led !== want.yellow_led || got.green_led !== want.green_led ||
             got.average_degrees !== want.average_degrees ||
             got.passthrough_on !== want.passthrough_on) begin
            mismatches++;
            if (mismatches + unexpected <= 10) begin
               $write("ERROR: status word %0d: expected mode %0d r%b y%b g%b avg %0d pt %b,",
                      checked, want.mode, want.red_led, want.yellow_led, want.green_led,
                      want.average_degrees, want.passthrough_on);
               $display(" got mode %0d r%b y%b g%b avg %0d pt %b",
                        got.mode, got.red_led, got.yellow_led, got.green_led,
                        got.average_degrees, got.passthrough_on);
            end
         end
      endfunction
   endclass

   alarm_scoreboard sb = new();

   // Stimulus bookkeeping
   int unsigned target_deg = 0;   // degree value the current ten samples aim at
   int unsigned burst_left = 1;   // words left in the current sender burst
   int unsigned full_stalls = 0;  // edges where push met a full queue
   int unsigned settings = 1;     // register settings run through

   thermal_alarm_supervisor #(
      .SAMPLES_PER_AVERAGE(SAMPLES)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_command         (req_command),
      .req_adc_sample      (req_adc_sample),
      .empty               (empty),
      .pop                 (pop),
      .rsp_mode            (rsp_mode),
      .rsp_red_led         (rsp_red_led),
      .rsp_yellow_led      (rsp_yellow_led),
      .rsp_green_led       (rsp_green_led),
      .rsp_average_degrees (rsp_average_degrees),
      .rsp_passthrough_on  (rsp_passthrough_on),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #4 clock = ~clock;

   // Hard limit; the slowest correct run is far below this.
   initial begin
      #4_000_000;
      $display("tb_thermal_alarm_supervisor failed");
      $finish;
   end

   //--------------------------------------------------------------------------
   // Sender tasks
   //--------------------------------------------------------------------------

   // Offer one event word and hold it until the edge that takes it.
   task automatic send_word(cmd_type cmd, logic [ADC_W-1:0] raw);
      push           <= 1'b1;
      req_command    <= cmd;
      req_adc_sample <= raw;
      do begin
         @(posedge clock);
         if (full) full_stalls++;
      end while (full !== 1'b0);
      void'(sb.note_input(cmd, raw));
   endtask

   // Bursts of random length with random gaps; a gap of zero chains bursts
   // into longer stretches with no idling at all.
   task automatic pace();
      int unsigned gap;
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drain everything in flight.
   task automatic settle();
      push <= 1'b0;
      while (sb.pending_status.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      sb.write_reg(idx, CSR_DATA_W'(value));
   endtask

   // Pick the degree value for the next ten samples: ok, warning or danger
   // band of the current limits, anything when the band is empty.
   task automatic pick_target();
      int lo, hi;
      case ($urandom_range(0, 2))
         0: begin
            lo = 0;
            hi = sb.ok_limit;
         end
         1: begin
            lo = sb.ok_limit + 1;
            hi = int'(sb.danger_limit) - 1;
         end
         default: begin
            lo = (sb.danger_limit > sb.ok_limit) ? sb.danger_limit : sb.ok_limit + 1;
            hi = 500;
         end
      endcase
      if (lo > hi || hi > 500) target_deg = $urandom_range(0, 500);
      else target_deg = $urandom_range(lo, hi);
   endtask

   // Mostly well-formed: start from off, restart from shutdown, ticks that
   // steer the average, an acknowledge now and then in danger. The rest is
   // noise: any command with any sample.
   task automatic pick_word(output cmd_type cmd, output logic [ADC_W-1:0] raw);
      int unsigned r;
      if ($urandom_range(0, 99) < 12) begin
         cmd = cmd_type'($urandom_range(0, 3));
         raw = $urandom_range(0, 4095);
      end else begin
         if (sb.sample_count == 0) pick_target();
         case (sb.mode)
            MODE_OFF:      cmd = CMD_START;
            MODE_SHUTDOWN: cmd = CMD_RESTART;
            MODE_DANGER:   cmd = ($urandom_range(0, sb.ack_window) == 0) ? CMD_ACK : CMD_TICK;
            default:       cmd = CMD_TICK;
         endcase
         // smallest raw value that converts to the target, plus a jitter
         // that stays inside the same degree
         r = (target_deg * ADC_FULL + DEG_SCALE - 1) / DEG_SCALE + $urandom_range(0, 4);
         if ($urandom_range(0, 19) == 0) r = $urandom_range(0, 4095);
         raw = (r > 4095) ? 12'hFFF : ADC_W'(r);
      end
   endtask

   task automatic run_random(int unsigned goal);
      int unsigned start;
      cmd_type          cmd;
      logic [ADC_W-1:0] raw;
      start = sb.acted;
      while (sb.acted - start < goal) begin
         pick_word(cmd, raw);
         send_word(cmd, raw);
         pace();
      end
   endtask

   // Ignored presses and ticks while off, every command, both sample
   // extremes, a forced danger average, acknowledge, then presses that
   // cooling must ignore.
   task automatic run_directed();
      send_word(CMD_TICK, 12'hFFF);
      send_word(CMD_ACK, 12'h000);
      send_word(CMD_RESTART, 12'hFFF);
      send_word(CMD_START, 12'h000);
      repeat (9) send_word(CMD_TICK, 12'hFFF);
      send_word(CMD_TICK, 12'h000);         // ten samples, average 450
      send_word(CMD_TICK, 12'h800);         // averaging tick: danger
      send_word(CMD_TICK, 12'h800);
      send_word(CMD_ACK, 12'h555);          // into cooling
      send_word(CMD_ACK, 12'hAAA);
      send_word(CMD_START, 12'h000);
      send_word(CMD_RESTART, 12'hFFF);
      send_word(CMD_TICK, 12'hFFF);
   endtask

   //--------------------------------------------------------------------------
   // Main sequence: reset, directed words, then random phases, each under
   // its own register setting written while the block is idle.
   //--------------------------------------------------------------------------
   initial begin
      int unsigned ok_v, danger_v, window_v, cool_v;
      int unsigned failures;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: cooling count starts at 100 regardless of writes
      run_directed();
      run_random(190);

      for (int phase = 1; phase <= 6; phase++) begin
         case (phase)
            1: begin ok_v = 0;   danger_v = 1;   window_v = 1;   cool_v = 0;    end
            3: begin ok_v = 500; danger_v = 0;   window_v = 128; cool_v = 5;    end
            6: begin ok_v = 20;  danger_v = 500; window_v = 255; cool_v = 1023; end
            default: begin
               ok_v     = $urandom_range(10, 200);
               danger_v = ok_v + $urandom_range(1, 80);
               window_v = $urandom_range(2, 30);
               cool_v   = $urandom_range(0, 40);
            end
         endcase
         settle();
         write_csr(CSR_OK_LIMIT, ok_v);
         write_csr(CSR_DANGER_LIMIT, danger_v);
         write_csr(CSR_ACK_WINDOW, window_v);
         write_csr(CSR_COOLING, cool_v);
         csr_wr_en <= 1'b0;
         settings++;
         run_random(210);
      end

      // drain, then give late or extra words time to show up
      settle();
      repeat (12) @(posedge clock);

      failures = sb.mismatches + sb.unexpected + sb.pending_status.size();
      $display("Covered %0d event words (%0d acted on), %0d status words checked, %0d settings.",
               sb.accepted, sb.acted, sb.checked, settings);
      $display("Entered danger %0d, cooling %0d, failing %0d, shutdown %0d; %0d full stalls.",
               sb.mode_entries[MODE_DANGER], sb.mode_entries[MODE_COOLING],
               sb.mode_entries[MODE_FAILING], sb.mode_entries[MODE_SHUTDOWN], full_stalls);
      if (failures == 0) begin
         $display("tb_thermal_alarm_supervisor passed");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d missing", sb.mismatches, sb.unexpected,
                  sb.pending_status.size());
         $display("tb_thermal_alarm_supervisor failed");
      end
      $finish;
   end

   //--------------------------------------------------------------------------
   // Receiver: checks every status word taken, stalls on a random stall mask
   // that is redrawn when its age counter runs out (sometimes all clear), and twice holds off
   // for a long stretch so the queues fill and full pushes back.
   //--------------------------------------------------------------------------
   initial begin
      int unsigned  hold_left;
      int unsigned  holds_done;
      int unsigned  pattern_age;
      logic [7:0]   stall_mask;
      rsp_word_type got;
      hold_left   = 0;
      holds_done  = 0;
      pattern_age = 0;
      stall_mask  = '0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            got.mode            = mode_type'(rsp_mode);
            got.red_led         = rsp_red_led;
            got.yellow_led      = rsp_yellow_led;
            got.green_led       = rsp_green_led;
            got.average_degrees = rsp_average_degrees;
            got.passthrough_on  = rsp_passthrough_on;
            sb.check_result(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if ((holds_done == 0 && sb.accepted >= 300) ||
                      (holds_done == 1 && sb.accepted >= 1000)) begin
            hold_left = 80;
            holds_done++;
            pop <= 1'b0;
         end else begin
            if (pattern_age == 0) begin
               pattern_age = 32;
               stall_mask  = ($urandom_range(0, 2) == 0) ? 8'h00 :
                             8'($urandom()) & 8'($urandom());
            end
            pattern_age--;
            pop <= !stall_mask[pattern_age % 8];
         end
      end
   end

endmodule
